>>> rtl/swl_pkg.sv
// Shared types, constants and helper functions for the soil worm lattice update block.
package swl_pkg;

    localparam int SIDE      = 32;
    localparam int STEP_BITS = 32;
    localparam int COORD_W   = $clog2(SIDE);
    localparam int CELLS     = SIDE * SIDE * SIDE;
    localparam int CELL_W    = $clog2(CELLS);
    localparam int IN_COORD_W = 5;
    localparam int CODE_W    = 3;
    localparam int PROB_W    = 17;
    localparam int RAND_W    = 16;
    localparam int OUT_W     = 32;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;

    typedef logic [CODE_W-1:0]     code_t;
    typedef logic [COORD_W-1:0]    coord_t;
    typedef logic [IN_COORD_W-1:0] in_coord_t;
    typedef logic [CELL_W-1:0]     cell_idx_t;
    typedef logic [STEP_BITS-1:0]  step_t;
    typedef logic [PROB_W-1:0]     prob_t;
    typedef logic [RAND_W-1:0]     rand_t;
    typedef logic [REG_IDX_W-1:0]  reg_idx_t;

    localparam code_t SITE_EMPTY    = 3'd0;
    localparam code_t SITE_NUTRIENT = 3'd1;
    localparam code_t SITE_SOIL     = 3'd2;
    localparam code_t SITE_GREEN    = 3'd3;
    localparam code_t SITE_BLUE     = 3'd4;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    localparam reg_idx_t REG_FILL        = 3'd0;
    localparam reg_idx_t REG_DEATH       = 3'd1;
    localparam reg_idx_t REG_GREEN_BREED = 3'd2;
    localparam reg_idx_t REG_GREEN_LEAVE = 3'd3;
    localparam reg_idx_t REG_BLUE_BREED  = 3'd4;
    localparam reg_idx_t REG_BLUE_LEAVE  = 3'd5;

    localparam prob_t FILL_RESET        = 17'd32768;
    localparam prob_t DEATH_RESET       = 17'd1638;
    localparam prob_t GREEN_BREED_RESET = 17'd32768;
    localparam prob_t GREEN_LEAVE_RESET = 17'd32768;
    localparam prob_t BLUE_BREED_RESET  = 17'd65536;
    localparam prob_t BLUE_LEAVE_RESET  = 17'd0;

    typedef struct packed {
        prob_t fill;
        prob_t death;
        prob_t green_breed;
        prob_t green_leave;
        prob_t blue_breed;
        prob_t blue_leave;
    } prob_cfg_t;

    typedef struct packed {
        code_t site_code;
        logic  site_fill;
        logic  nbr_write;
        logic  nbr_clear;
        logic  event_hit;
    } rule_t;

    // input coordinate modulo SIDE by repeated conditional subtract
    function automatic coord_t coord_wrap(input in_coord_t v);
        logic [IN_COORD_W+1:0] t;
        t = {2'b00, v};
        for (int i = 0; i < 8; i++) begin
            if (t >= (IN_COORD_W+2)'(SIDE)) begin
                t = t - (IN_COORD_W+2)'(SIDE);
            end
        end
        return COORD_W'(t);
    endfunction

    function automatic coord_t coord_step(input coord_t c, input logic plus);
        coord_t r;
        if (plus) begin
            r = (c == COORD_W'(SIDE - 1)) ? '0 : c + 1'b1;
        end else begin
            r = (c == '0) ? COORD_W'(SIDE - 1) : c - 1'b1;
        end
        return r;
    endfunction

    function automatic cell_idx_t cell_index(input coord_t x, input coord_t y, input coord_t z);
        return CELL_W'((CELL_W'(x) * CELL_W'(SIDE) + CELL_W'(y)) * CELL_W'(SIDE) + CELL_W'(z));
    endfunction

    function automatic logic passes(input rand_t draw, input prob_t prob);
        return {1'b0, draw} < prob;
    endfunction

endpackage

>>> rtl/swl_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
module swl_ram #(
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/swl_regs.sv
// APB configuration registers holding the six probability thresholds.
module swl_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [swl_pkg::PADDR_W-1:0] paddr,
    input  logic [swl_pkg::PDATA_W-1:0] pwdata,
    output logic [swl_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output swl_pkg::prob_cfg_t          cfg
);

    swl_pkg::prob_cfg_t cfg_reg;
    swl_pkg::reg_idx_t  idx;
    swl_pkg::prob_t     wval;
    logic               wr_en;

    assign idx    = paddr[swl_pkg::PADDR_W-1:2];
    assign wval   = pwdata[swl_pkg::PROB_W-1:0];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fill        <= swl_pkg::FILL_RESET;
            cfg_reg.death       <= swl_pkg::DEATH_RESET;
            cfg_reg.green_breed <= swl_pkg::GREEN_BREED_RESET;
            cfg_reg.green_leave <= swl_pkg::GREEN_LEAVE_RESET;
            cfg_reg.blue_breed  <= swl_pkg::BLUE_BREED_RESET;
            cfg_reg.blue_leave  <= swl_pkg::BLUE_LEAVE_RESET;
        end else if (wr_en) begin
            unique case (idx)
                swl_pkg::REG_FILL:        cfg_reg.fill        <= wval;
                swl_pkg::REG_DEATH:       cfg_reg.death       <= wval;
                swl_pkg::REG_GREEN_BREED: cfg_reg.green_breed <= wval;
                swl_pkg::REG_GREEN_LEAVE: cfg_reg.green_leave <= wval;
                swl_pkg::REG_BLUE_BREED:  cfg_reg.blue_breed  <= wval;
                swl_pkg::REG_BLUE_LEAVE:  cfg_reg.blue_leave  <= wval;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            swl_pkg::REG_FILL:        prdata = swl_pkg::PDATA_W'(cfg_reg.fill);
            swl_pkg::REG_DEATH:       prdata = swl_pkg::PDATA_W'(cfg_reg.death);
            swl_pkg::REG_GREEN_BREED: prdata = swl_pkg::PDATA_W'(cfg_reg.green_breed);
            swl_pkg::REG_GREEN_LEAVE: prdata = swl_pkg::PDATA_W'(cfg_reg.green_leave);
            swl_pkg::REG_BLUE_BREED:  prdata = swl_pkg::PDATA_W'(cfg_reg.blue_breed);
            swl_pkg::REG_BLUE_LEAVE:  prdata = swl_pkg::PDATA_W'(cfg_reg.blue_leave);
            default:                  prdata = '0;
        endcase
    end

endmodule

>>> rtl/swl_rule.sv
// Site update rule: decides new site and neighbour contents from the two codes read.
module swl_rule (
    input  swl_pkg::code_t     here,
    input  swl_pkg::code_t     target,
    input  swl_pkg::rand_t     rand_first,
    input  swl_pkg::rand_t     rand_second,
    input  swl_pkg::prob_cfg_t cfg,
    output swl_pkg::rule_t     rule
);

    logic           is_worm;
    swl_pkg::prob_t breed;
    swl_pkg::prob_t leave;

    assign is_worm = (here == swl_pkg::SITE_GREEN) || (here == swl_pkg::SITE_BLUE);
    assign breed   = (here == swl_pkg::SITE_GREEN) ? cfg.green_breed : cfg.blue_breed;
    assign leave   = (here == swl_pkg::SITE_GREEN) ? cfg.green_leave : cfg.blue_leave;

    always_comb begin
        rule.site_code = here;
        rule.site_fill = 1'b0;
        rule.nbr_write = 1'b0;
        rule.nbr_clear = 1'b0;
        rule.event_hit = 1'b0;
        if (here == swl_pkg::SITE_EMPTY || here == swl_pkg::SITE_NUTRIENT) begin
            if (target == swl_pkg::SITE_SOIL && swl_pkg::passes(rand_first, cfg.fill)) begin
                rule.site_code = swl_pkg::SITE_SOIL;
                rule.site_fill = 1'b1;
            end
        end else if (is_worm) begin
            rule.site_code = swl_pkg::SITE_EMPTY;
            if (!swl_pkg::passes(rand_first, cfg.death)) begin
                rule.nbr_write = 1'b1;
                case (target)
                    swl_pkg::SITE_NUTRIENT: begin
                        if (swl_pkg::passes(rand_second, breed)) begin
                            rule.site_code = here;
                        end
                    end
                    swl_pkg::SITE_SOIL: begin
                        if (swl_pkg::passes(rand_second, leave)) begin
                            rule.site_code = swl_pkg::SITE_NUTRIENT;
                        end
                        rule.nbr_clear = 1'b1;
                        rule.event_hit = 1'b1;
                    end
                    swl_pkg::SITE_GREEN, swl_pkg::SITE_BLUE: begin
                        rule.site_code = target;
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> rtl/soil_worm_lattice_update.sv
// Top level: lattice and creation-step memories with the update sequencer.
//
// An update reads the site in the accept cycle and the neighbour in the next (ST_READ_NBR),
// then writes the neighbour where the rule calls for it (ST_WRITE_NBR) and the site
// (ST_WRITE_SITE), all through the single write port of each memory. A load writes both
// memories in ST_LOAD. One item is in work at a time; s_ready is high only between items. A
// finished result waits in the output register while the next item is taken; the final write
// state holds only if a previous result is still not taken. After reset a clearing pass over
// all SIDE^3 (32768) cells zeroes the creation-step memory with s_ready low; configuration
// writes are taken throughout. Lattice sites must be loaded before they are used in an update.
module soil_worm_lattice_update (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [swl_pkg::PADDR_W-1:0] paddr,
    input  logic [swl_pkg::PDATA_W-1:0] pwdata,
    output logic [swl_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_operation,
    input  logic [4:0]                  s_site_x,
    input  logic [4:0]                  s_site_y,
    input  logic [4:0]                  s_site_z,
    input  logic [1:0]                  s_axis,
    input  logic                        s_direction,
    input  logic [15:0]                 s_rand_first,
    input  logic [15:0]                 s_rand_second,
    input  logic [2:0]                  s_load_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_event_valid,
    output logic [31:0]                 m_event_step,
    output logic [31:0]                 m_soil_lifetime
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_NBR,
        ST_WRITE_NBR,
        ST_WRITE_SITE,
        ST_LOAD
    } state_t;

    state_t              state_reg;
    swl_pkg::cell_idx_t  clr_cnt_reg;
    swl_pkg::step_t      step_reg;
    swl_pkg::cell_idx_t  site_idx_reg;
    swl_pkg::cell_idx_t  nbr_idx_reg;
    swl_pkg::rand_t      r1_reg;
    swl_pkg::rand_t      r2_reg;
    swl_pkg::code_t      load_reg;
    swl_pkg::code_t      here_reg;
    swl_pkg::code_t      site_code_reg;
    logic                site_fill_reg;
    logic                evt_reg;
    swl_pkg::step_t      life_reg;
    logic                m_valid_reg;
    logic                m_event_valid_reg;
    logic [31:0]         m_event_step_reg;
    logic [31:0]         m_soil_lifetime_reg;

    swl_pkg::prob_cfg_t  cfg;
    swl_pkg::rule_t      rule;
    swl_pkg::coord_t     cx, cy, cz, nx, ny, nz;
    swl_pkg::cell_idx_t  in_site_idx, in_nbr_idx;
    swl_pkg::cell_idx_t  rd_addr;
    logic                lat_we, cre_we;
    swl_pkg::cell_idx_t  lat_waddr, cre_waddr;
    swl_pkg::code_t      lat_wdata, lat_rdata;
    swl_pkg::step_t      cre_wdata, cre_rdata;
    logic                out_free;
    logic                out_load;

    swl_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    swl_ram #(.WIDTH(swl_pkg::CODE_W), .ADDR_W(swl_pkg::CELL_W)) u_lattice (
        .aclk  (aclk),
        .we    (lat_we),
        .waddr (lat_waddr),
        .wdata (lat_wdata),
        .raddr (rd_addr),
        .rdata (lat_rdata)
    );

    swl_ram #(.WIDTH(swl_pkg::STEP_BITS), .ADDR_W(swl_pkg::CELL_W)) u_creation (
        .aclk  (aclk),
        .we    (cre_we),
        .waddr (cre_waddr),
        .wdata (cre_wdata),
        .raddr (rd_addr),
        .rdata (cre_rdata)
    );

    swl_rule u_rule (
        .here        (here_reg),
        .target      (lat_rdata),
        .rand_first  (r1_reg),
        .rand_second (r2_reg),
        .cfg         (cfg),
        .rule        (rule)
    );

    assign cx = swl_pkg::coord_wrap(s_site_x);
    assign cy = swl_pkg::coord_wrap(s_site_y);
    assign cz = swl_pkg::coord_wrap(s_site_z);

    always_comb begin
        nx = cx;
        ny = cy;
        nz = cz;
        case (s_axis)
            swl_pkg::AXIS_X: nx = swl_pkg::coord_step(cx, s_direction);
            swl_pkg::AXIS_Y: ny = swl_pkg::coord_step(cy, s_direction);
            swl_pkg::AXIS_Z: nz = swl_pkg::coord_step(cz, s_direction);
            default: ;
        endcase
    end

    assign in_site_idx = swl_pkg::cell_index(cx, cy, cz);
    assign in_nbr_idx  = swl_pkg::cell_index(nx, ny, nz);

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = ((state_reg == ST_WRITE_SITE) || (state_reg == ST_LOAD)) && out_free;
    assign rd_addr  = (state_reg == ST_IDLE) ? in_site_idx : nbr_idx_reg;

    always_comb begin
        lat_we    = 1'b0;
        lat_waddr = site_idx_reg;
        lat_wdata = here_reg;
        cre_we    = 1'b0;
        cre_waddr = site_idx_reg;
        cre_wdata = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cre_we    = 1'b1;
                cre_waddr = clr_cnt_reg;
            end
            ST_IDLE, ST_READ_NBR: ;
            ST_WRITE_NBR: begin
                lat_we    = rule.nbr_write;
                lat_waddr = nbr_idx_reg;
                lat_wdata = here_reg;
                cre_we    = rule.nbr_clear;
                cre_waddr = nbr_idx_reg;
            end
            ST_WRITE_SITE: begin
                lat_we    = 1'b1;
                lat_wdata = site_code_reg;
                cre_we    = site_fill_reg;
                cre_wdata = step_reg;
            end
            ST_LOAD: begin
                lat_we    = 1'b1;
                lat_wdata = load_reg;
                cre_we    = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == swl_pkg::CELL_W'(swl_pkg::CELLS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        site_idx_reg <= in_site_idx;
                        nbr_idx_reg  <= in_nbr_idx;
                        r1_reg       <= s_rand_first;
                        r2_reg       <= s_rand_second;
                        load_reg     <= s_load_value;
                        state_reg    <= (s_operation == swl_pkg::OP_LOAD) ? ST_LOAD : ST_READ_NBR;
                    end
                end
                ST_READ_NBR: begin
                    here_reg  <= lat_rdata;
                    state_reg <= ST_WRITE_NBR;
                end
                ST_WRITE_NBR: begin
                    site_code_reg <= rule.site_code;
                    site_fill_reg <= rule.site_fill;
                    evt_reg       <= rule.event_hit;
                    life_reg      <= step_reg - cre_rdata;
                    state_reg     <= ST_WRITE_SITE;
                end
                ST_WRITE_SITE: begin
                    if (out_free) begin
                        m_event_valid_reg   <= evt_reg;
                        m_event_step_reg    <= swl_pkg::OUT_W'(step_reg);
                        m_soil_lifetime_reg <= evt_reg ? swl_pkg::OUT_W'(life_reg) : '0;
                        step_reg            <= step_reg + 1'b1;
                        state_reg           <= ST_IDLE;
                    end
                end
                ST_LOAD: begin
                    if (out_free) begin
                        m_event_valid_reg   <= 1'b0;
                        m_event_step_reg    <= swl_pkg::OUT_W'(step_reg);
                        m_soil_lifetime_reg <= '0;
                        state_reg           <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_event_valid   = m_event_valid_reg;
    assign m_event_step    = m_event_step_reg;
    assign m_soil_lifetime = m_soil_lifetime_reg;

endmodule

>>> rtl/swl_checker.sv
// Port-level assertion checker for the soil worm lattice update block, with its bind.
module swl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_event_valid,
    input logic [31:0] m_event_step,
    input logic [31:0] m_soil_lifetime
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_step)
            && $stable(m_soil_lifetime) && $stable(m_event_valid))
        else $error("stalled result changed");

    // no lifetime without an event
    a_life_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_event_valid |-> m_soil_lifetime == 32'd0)
        else $error("lifetime reported without event");

    // one item in work at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted while another is in work");

    // a result never appears the cycle right after acceptance
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result too early");

endmodule

bind soil_worm_lattice_update swl_checker u_swl_checker (.*);

>>> bench/soil_worm_lattice_update_test.sv
// Self-checking testbench for soil_worm_lattice_update: directed table, then random phases.
module soil_worm_lattice_update_test;
    timeunit 1ns;
    timeprecision 1ps;
    import swl_pkg::*;

    localparam logic [1:0] AXIS_SELF = 2'd3;
    localparam logic       DIR_MINUS = 1'b0;
    localparam logic       DIR_PLUS  = 1'b1;
    localparam code_t      SITE_SPARE = 3'd7;
    localparam prob_t      PROB_ZERO = 17'd0;
    localparam prob_t      PROB_ONE  = 17'd65536;
    localparam int         PHASES = 5;
    localparam int         PHASE_ITEMS = 125;
    localparam int         SETTLE_CYCLES = 8;

    typedef struct packed {
        logic       op;
        in_coord_t  x;
        in_coord_t  y;
        in_coord_t  z;
        logic [1:0] axis;
        logic       dir;
        rand_t      r1;
        rand_t      r2;
        code_t      load_value;
    } lattice_item_t;

    typedef struct packed {
        logic  hit;
        step_t step;
        step_t life;
    } soil_event_t;

    typedef struct packed {
        lattice_item_t item;
        logic          typed;
        soil_event_t   want;
    } plan_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 psel, penable, pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_operation;
    logic [4:0]           s_site_x, s_site_y, s_site_z;
    logic [1:0]           s_axis;
    logic                 s_direction;
    logic [15:0]          s_rand_first, s_rand_second;
    logic [2:0]           s_load_value;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_event_valid;
    logic [31:0]          m_event_step;
    logic [31:0]          m_soil_lifetime;

    code_t       site_code [CELLS];
    step_t       born_step [CELLS];
    bit          site_loaded [CELLS];
    step_t       step_now;
    prob_t       prob_reg [8];
    soil_event_t pending_events [$];
    plan_row_t   plan [$];
    int          failures = 0;
    int          src_calm = 0;
    int          sink_calm = 0;

    soil_worm_lattice_update DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_site_x       (s_site_x),
        .s_site_y       (s_site_y),
        .s_site_z       (s_site_z),
        .s_axis         (s_axis),
        .s_direction    (s_direction),
        .s_rand_first   (s_rand_first),
        .s_rand_second  (s_rand_second),
        .s_load_value   (s_load_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_valid  (m_event_valid),
        .m_event_step   (m_event_step),
        .m_soil_lifetime(m_soil_lifetime)
    );

    always #5 aclk = ~aclk;

    function automatic int cell_of(input int x, input int y, input int z);
        return ((x % SIDE) * SIDE + (y % SIDE)) * SIDE + (z % SIDE);
    endfunction

    function automatic int wrap_coord(input int c, input logic plus);
        return plus ? (c + 1) % SIDE : (c + SIDE - 1) % SIDE;
    endfunction

    function automatic void neighbour_of(input lattice_item_t it, output int nx,
                                         output int ny, output int nz);
        nx = it.x % SIDE;
        ny = it.y % SIDE;
        nz = it.z % SIDE;
        case (it.axis)
            AXIS_X: nx = wrap_coord(nx, it.dir);
            AXIS_Y: ny = wrap_coord(ny, it.dir);
            AXIS_Z: nz = wrap_coord(nz, it.dir);
            default: ;
        endcase
    endfunction

    function automatic bit chance(input rand_t draw, input prob_t p);
        return {1'b0, draw} < p;
    endfunction

    // Applies one item to the shadow lattice and returns the result it must produce.
    function automatic soil_event_t advance_lattice(input lattice_item_t it);
        soil_event_t ev;
        int          nx, ny, nz, site, nbr;
        code_t       here, target;
        prob_t       breed, leave;
        ev.hit = 1'b0;
        ev.step = step_now;
        ev.life = '0;
        site = cell_of(it.x, it.y, it.z);
        if (it.op == OP_LOAD) begin
            site_code[site] = it.load_value;
            born_step[site] = '0;
            site_loaded[site] = 1'b1;
            return ev;
        end
        neighbour_of(it, nx, ny, nz);
        nbr = cell_of(nx, ny, nz);
        here = site_code[site];
        if (here == SITE_EMPTY || here == SITE_NUTRIENT) begin
            if (site_code[nbr] == SITE_SOIL && chance(it.r1, prob_reg[REG_FILL])) begin
                site_code[site] = SITE_SOIL;
                born_step[site] = step_now;
            end
        end else if (here == SITE_GREEN || here == SITE_BLUE) begin
            breed = (here == SITE_GREEN) ? prob_reg[REG_GREEN_BREED] : prob_reg[REG_BLUE_BREED];
            leave = (here == SITE_GREEN) ? prob_reg[REG_GREEN_LEAVE] : prob_reg[REG_BLUE_LEAVE];
            if (chance(it.r1, prob_reg[REG_DEATH])) begin
                site_code[site] = SITE_EMPTY;
            end else begin
                target = site_code[nbr];
                site_code[nbr] = here;
                site_code[site] = SITE_EMPTY;
                if (target == SITE_NUTRIENT) begin
                    if (chance(it.r2, breed)) begin
                        site_code[site] = here;
                    end
                end else if (target == SITE_SOIL) begin
                    if (chance(it.r2, leave)) begin
                        site_code[site] = SITE_NUTRIENT;
                    end
                    ev.hit = 1'b1;
                    ev.life = step_now - born_step[nbr];
                    born_step[nbr] = '0;
                end else if (target == SITE_GREEN || target == SITE_BLUE) begin
                    site_code[site] = target;
                end
            end
        end
        step_now = step_now + 1'b1;
        return ev;
    endfunction

    function automatic int idle_cycles(inout int calm_left);
        if (calm_left > 0) begin
            calm_left = calm_left - 1;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    // mostly the wrap corner of the lattice, so worms and soil meet often
    function automatic in_coord_t pick_coord();
        int v;
        if ($urandom_range(0, 9) == 0) begin
            return in_coord_t'($urandom_range(0, SIDE - 1));
        end
        v = $urandom_range(0, 5);
        return in_coord_t'(v < 3 ? v : SIDE - 6 + v);
    endfunction

    function automatic rand_t pick_draw();
        int k;
        k = $urandom_range(0, 7);
        if (k == 0) begin
            return '0;
        end else if (k == 1) begin
            return '1;
        end
        return rand_t'($urandom_range(0, 65535));
    endfunction

    function automatic prob_t pick_prob();
        int k;
        k = $urandom_range(0, 5);
        if (k == 0) begin
            return PROB_ZERO;
        end else if (k == 1) begin
            return PROB_ONE - 1'b1;
        end else if (k == 2) begin
            return PROB_ONE;
        end
        return prob_t'($urandom_range(0, 65536));
    endfunction

    // updates only touch loaded sites; an unloaded site or neighbour gets loaded instead
    function automatic lattice_item_t random_item();
        lattice_item_t it;
        int            nx, ny, nz;
        it.x = pick_coord();
        it.y = pick_coord();
        it.z = pick_coord();
        it.axis = ($urandom_range(0, 15) == 0) ? AXIS_SELF : 2'($urandom_range(0, 2));
        it.dir = 1'($urandom_range(0, 1));
        it.r1 = pick_draw();
        it.r2 = pick_draw();
        it.load_value = ($urandom_range(0, 15) == 0) ? code_t'($urandom_range(5, 7))
                                                     : code_t'($urandom_range(0, 4));
        it.op = ($urandom_range(0, 4) == 0) ? OP_LOAD : OP_UPDATE;
        if (it.op == OP_UPDATE) begin
            neighbour_of(it, nx, ny, nz);
            if (!site_loaded[cell_of(it.x, it.y, it.z)]) begin
                it.op = OP_LOAD;
            end else if (!site_loaded[cell_of(nx, ny, nz)]) begin
                it.op = OP_LOAD;
                it.x = in_coord_t'(nx);
                it.y = in_coord_t'(ny);
                it.z = in_coord_t'(nz);
            end
        end
        return it;
    endfunction

    function automatic plan_row_t load_row(input int x, input int y, input int z,
                                           input code_t v, input int st);
        plan_row_t p;
        p = '0;
        p.item.op = OP_LOAD;
        p.item.x = in_coord_t'(x);
        p.item.y = in_coord_t'(y);
        p.item.z = in_coord_t'(z);
        p.item.load_value = v;
        p.typed = 1'b1;
        p.want.step = step_t'(st);
        return p;
    endfunction

    function automatic plan_row_t update_row(input int x, input int y, input int z,
                                             input logic [1:0] axis, input logic dir,
                                             input rand_t r1, input rand_t r2,
                                             input bit typed, input bit hit,
                                             input int st, input int life);
        plan_row_t p;
        p = '0;
        p.item.op = OP_UPDATE;
        p.item.x = in_coord_t'(x);
        p.item.y = in_coord_t'(y);
        p.item.z = in_coord_t'(z);
        p.item.axis = axis;
        p.item.dir = dir;
        p.item.r1 = r1;
        p.item.r2 = r2;
        p.typed = typed;
        p.want.hit = hit;
        p.want.step = step_t'(st);
        p.want.life = step_t'(life);
        return p;
    endfunction

    task automatic send_item(input lattice_item_t it, input bit typed, input soil_event_t want);
        int gap;
        soil_event_t ev;
        gap = idle_cycles(src_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_operation <= it.op;
        s_site_x <= it.x;
        s_site_y <= it.y;
        s_site_z <= it.z;
        s_axis <= it.axis;
        s_direction <= it.dir;
        s_rand_first <= it.r1;
        s_rand_second <= it.r2;
        s_load_value <= it.load_value;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        ev = advance_lattice(it);
        pending_events.push_back(typed ? want : ev);
        @(negedge aclk);
    endtask

    task automatic write_prob(input reg_idx_t idx, input prob_t v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= PDATA_W'(v);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        prob_reg[idx] = v;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic apply_setting(input prob_t fill, input prob_t death,
                                 input prob_t green_breed, input prob_t green_leave,
                                 input prob_t blue_breed, input prob_t blue_leave);
        write_prob(REG_FILL, fill);
        write_prob(REG_DEATH, death);
        write_prob(REG_GREEN_BREED, green_breed);
        write_prob(REG_GREEN_LEAVE, green_leave);
        write_prob(REG_BLUE_BREED, blue_breed);
        write_prob(REG_BLUE_LEAVE, blue_leave);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_events.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        s_operation = OP_UPDATE;
        s_site_x = '0;
        s_site_y = '0;
        s_site_z = '0;
        s_axis = AXIS_X;
        s_direction = DIR_MINUS;
        s_rand_first = '0;
        s_rand_second = '0;
        s_load_value = SITE_EMPTY;
        step_now = '0;
        foreach (born_step[i]) begin
            born_step[i] = '0;
            site_code[i] = SITE_EMPTY;
            site_loaded[i] = 1'b0;
        end
        prob_reg[REG_FILL] = FILL_RESET;
        prob_reg[REG_DEATH] = DEATH_RESET;
        prob_reg[REG_GREEN_BREED] = GREEN_BREED_RESET;
        prob_reg[REG_GREEN_LEAVE] = GREEN_LEAVE_RESET;
        prob_reg[REG_BLUE_BREED] = BLUE_BREED_RESET;
        prob_reg[REG_BLUE_LEAVE] = BLUE_LEAVE_RESET;

        // green into soil across the x wrap, leaving nutrient
        plan.push_back(load_row(0, 0, 0, SITE_GREEN, 0));
        plan.push_back(load_row(SIDE - 1, 0, 0, SITE_SOIL, 0));
        plan.push_back(update_row(0, 0, 0, AXIS_X, DIR_MINUS, '1, '0, 1, 1, 0, 0));
        // nutrient fills to soil, then a worm reports its lifetime
        plan.push_back(load_row(0, 0, 1, SITE_SOIL, 1));
        plan.push_back(update_row(0, 0, 0, AXIS_Z, DIR_PLUS, '0, '0, 1, 0, 1, 0));
        plan.push_back(update_row(SIDE - 1, 0, 0, AXIS_X, DIR_PLUS, '1, '1, 1, 1, 2, 1));
        // death
        plan.push_back(load_row(0, SIDE - 1, 0, SITE_NUTRIENT, 3));
        plan.push_back(update_row(0, 0, 0, AXIS_Y, DIR_MINUS, '0, '0, 1, 0, 3, 0));
        // blue breeds on nutrient, then meets a worm with draw at the death boundary
        plan.push_back(load_row(SIDE - 1, SIDE - 1, SIDE - 1, SITE_BLUE, 4));
        plan.push_back(load_row(SIDE - 1, SIDE - 1, 0, SITE_NUTRIENT, 4));
        plan.push_back(update_row(SIDE - 1, SIDE - 1, SIDE - 1, AXIS_Z, DIR_PLUS, '1, '1,
                                  1, 0, 4, 0));
        plan.push_back(update_row(SIDE - 1, SIDE - 1, SIDE - 1, AXIS_Z, DIR_PLUS,
                                  rand_t'(DEATH_RESET), '0, 0, 0, 0, 0));
        // blue into soil with zero leave probability
        plan.push_back(load_row(SIDE - 1, SIDE - 2, SIDE - 1, SITE_SOIL, 6));
        plan.push_back(update_row(SIDE - 1, SIDE - 1, SIDE - 1, AXIS_Y, DIR_MINUS, 16'd40000,
                                  '0, 1, 1, 6, 6));
        // neighbour is the site itself
        plan.push_back(update_row(SIDE - 1, SIDE - 2, SIDE - 1, AXIS_SELF, DIR_PLUS, '1, '0,
                                  0, 0, 0, 0));
        // spare code: idle when chosen, overwritten when entered
        plan.push_back(load_row(5, 5, 5, SITE_SPARE, 8));
        plan.push_back(load_row(5, 5, 6, SITE_SOIL, 8));
        plan.push_back(update_row(5, 5, 5, AXIS_Z, DIR_PLUS, '0, '0, 1, 0, 8, 0));
        plan.push_back(load_row(5, 5, 4, SITE_GREEN, 9));
        plan.push_back(update_row(5, 5, 4, AXIS_Z, DIR_PLUS, '1, '0, 0, 0, 0, 0));
        // fill and breed draws at the probability boundary
        plan.push_back(load_row(6, 5, 6, SITE_EMPTY, 10));
        plan.push_back(update_row(6, 5, 6, AXIS_X, DIR_MINUS, rand_t'(FILL_RESET), '0,
                                  1, 0, 10, 0));
        plan.push_back(load_row(7, 7, 7, SITE_GREEN, 11));
        plan.push_back(load_row(7, 7, 8, SITE_NUTRIENT, 11));
        plan.push_back(update_row(7, 7, 7, AXIS_Z, DIR_PLUS, '1,
                                  rand_t'(GREEN_BREED_RESET - 1'b1), 1, 0, 11, 0));

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            send_item(plan[i].item, plan[i].typed, plan[i].want);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                1: apply_setting(PROB_ZERO, PROB_ZERO, PROB_ZERO, PROB_ZERO, PROB_ZERO,
                                 PROB_ZERO);
                2: apply_setting(PROB_ONE, PROB_ONE, PROB_ONE, PROB_ONE, PROB_ONE, PROB_ONE);
                default: apply_setting(pick_prob(), pick_prob(), pick_prob(), pick_prob(),
                                       pick_prob(), pick_prob());
            endcase
            repeat (PHASE_ITEMS) begin
                send_item(random_item(), 1'b0, '0);
            end
        end
        drain();

        if (failures == 0 && pending_events.size() == 0) begin
            $display("soil_worm_lattice_update: match");
        end else begin
            $display("soil_worm_lattice_update: mismatch");
        end
        $finish;
    end

    initial begin
        soil_event_t want;
        int          stall;
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            stall = idle_cycles(sink_calm);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (pending_events.size() == 0) begin
                failures++;
                if (failures <= 200) begin
                    $display("%0t ns: unexpected item, got hit %0d step %0d life %0d",
                             $time, m_event_valid, m_event_step, m_soil_lifetime);
                end
            end else begin
                want = pending_events.pop_front();
                if (m_event_valid !== want.hit || m_event_step !== want.step ||
                    m_soil_lifetime !== want.life) begin
                    failures++;
                    if (failures <= 200) begin
                        $display("%0t ns: expected hit %0d step %0d life %0d, got hit %0d step %0d life %0d",
                                 $time, want.hit, want.step, want.life,
                                 m_event_valid, m_event_step, m_soil_lifetime);
                    end
                end
            end
            @(negedge aclk);
        end
    end

    initial begin
        #5_000_000;
        $display("soil_worm_lattice_update: mismatch");
        $finish;
    end

endmodule
